@@ src/fau_pkg.sv @@
// shared types and constants for the fraction arithmetic unit
package fau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD_INIT,
    ST_GCD_RUN,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_MUL,
    ST_FIN
  } state_t;

  localparam int unsigned NUM_OUT_W = 33;
  localparam int unsigned DEN_OUT_W = 32;
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned MUL_W     = 32;

  typedef struct packed {
    logic       load;
    logic       gcd_init;
    logic       gcd_step;
    logic       gcd_save;
    logic       div_init;
    logic       div_step;
    logic       div_write;
    logic       side;
    logic       part;
    logic       mul_en;
    logic [1:0] mul_idx;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic gcd_zero;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

@@ src/fau_ctrl.sv @@
// controller state machine sequencing gcd, divisions and products
module fau_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fau_pkg::status_t status,
  output fau_pkg::cmd_t    cmd
);

  fau_pkg::state_t state_r, state_nxt;
  logic            side_r, side_nxt;
  logic            part_r, part_nxt;
  logic [1:0]      mcnt_r, mcnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fau_pkg::ST_IDLE;
      side_r  <= 1'b0;
      part_r  <= 1'b0;
      mcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
      part_r  <= part_nxt;
      mcnt_r  <= mcnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    part_nxt  = part_r;
    mcnt_nxt  = mcnt_r;
    unique case (state_r)
      fau_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = fau_pkg::ST_GCD_INIT;
          side_nxt  = 1'b0;
          part_nxt  = 1'b0;
        end
      end
      fau_pkg::ST_GCD_INIT: state_nxt = fau_pkg::ST_GCD_RUN;
      fau_pkg::ST_GCD_RUN: begin
        if (status.gcd_done) begin
          part_nxt = 1'b0;
          if (!status.gcd_zero) begin
            state_nxt = fau_pkg::ST_DIV_INIT;
          end else if (!side_r) begin
            state_nxt = fau_pkg::ST_GCD_INIT;
            side_nxt  = 1'b1;
          end else begin
            state_nxt = fau_pkg::ST_MUL;
            mcnt_nxt  = 2'd0;
          end
        end
      end
      fau_pkg::ST_DIV_INIT: state_nxt = fau_pkg::ST_DIV_RUN;
      fau_pkg::ST_DIV_RUN: begin
        if (status.div_done) begin
          if (!part_r) begin
            state_nxt = fau_pkg::ST_DIV_INIT;
            part_nxt  = 1'b1;
          end else if (!side_r) begin
            state_nxt = fau_pkg::ST_GCD_INIT;
            side_nxt  = 1'b1;
            part_nxt  = 1'b0;
          end else begin
            state_nxt = fau_pkg::ST_MUL;
            mcnt_nxt  = 2'd0;
          end
        end
      end
      fau_pkg::ST_MUL: begin
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) begin
          state_nxt = fau_pkg::ST_FIN;
        end
      end
      fau_pkg::ST_FIN: begin
        if (!status.out_busy) begin
          state_nxt = fau_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.side    = side_r;
    cmd.part    = part_r;
    cmd.mul_idx = mcnt_r;
    in_ready    = 1'b0;
    unique case (state_r)
      fau_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      fau_pkg::ST_GCD_INIT: cmd.gcd_init = 1'b1;
      fau_pkg::ST_GCD_RUN: begin
        cmd.gcd_save = status.gcd_done;
        cmd.gcd_step = !status.gcd_done;
      end
      fau_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      fau_pkg::ST_DIV_RUN: begin
        cmd.div_write = status.div_done;
        cmd.div_step  = !status.div_done;
      end
      fau_pkg::ST_MUL: cmd.mul_en = 1'b1;
      fau_pkg::ST_FIN: cmd.out_load = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

@@ src/fau_dp.sv @@
// datapath: operand registers, binary gcd, restoring divider, shared multiplier
module fau_dp #(
  parameter int unsigned W = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fau_pkg::cmd_t                          cmd,
  output fau_pkg::status_t                       status,
  input  logic [1:0]                             in_operation,
  input  logic [fau_pkg::FIELD_W-1:0]            in_num_a,
  input  logic [fau_pkg::FIELD_W-1:0]            in_den_a,
  input  logic [fau_pkg::FIELD_W-1:0]            in_num_b,
  input  logic [fau_pkg::FIELD_W-1:0]            in_den_b,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fau_pkg::NUM_OUT_W-1:0]   out_result_num,
  output logic signed [fau_pkg::DEN_OUT_W-1:0]   out_result_den,
  output logic                                   out_first_irreducible,
  output logic                                   out_second_irreducible,
  output logic                                   out_first_positive,
  output logic                                   out_second_positive,
  output logic                                   out_error
);

  localparam int unsigned KW = $clog2(W);
  localparam int unsigned CW = $clog2(W + 1);

  function automatic logic signed [W-1:0] take(input logic [fau_pkg::FIELD_W-1:0] raw);
    logic [W-1:0] v;
    v = '0;
    for (int i = 0; i < W && i < fau_pkg::FIELD_W; i++) begin
      v[i] = raw[i];
    end
    return signed'(v);
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    return x[W-1] ? W'(-x) : W'(x);
  endfunction

  function automatic logic pos(input logic signed [W-1:0] n, input logic signed [W-1:0] d);
    return (n > 0 && d > 0) || (n < 0 && d < 0);
  endfunction

  fau_pkg::op_t       op_r;
  logic signed [W-1:0] na_r, da_r, nb_r, db_r;
  logic               pos_a_r, pos_b_r, den_zero_r, irr_a_r, irr_b_r;
  logic [W-1:0]       x_r, y_r, g_r;
  logic [KW-1:0]      k_r;
  logic [W-1:0]       q_r, rem_r;
  logic [CW-1:0]      cnt_r;
  logic               neg_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r;
  logic               out_valid_r;
  logic signed [fau_pkg::NUM_OUT_W-1:0] rn_r;
  logic signed [fau_pkg::DEN_OUT_W-1:0] rd_r;
  logic               fa_irr_r, fb_irr_r, fa_pos_r, fb_pos_r, err_r;

  logic signed [W-1:0] sn, sd, dv_src;
  logic [W-1:0]        g_val;
  logic [W:0]          rem_sh, diff;
  logic [W-1:0]        q_signed;
  logic signed [fau_pkg::MUL_W-1:0] ma, mb;
  logic signed [63:0]  prod;
  logic signed [fau_pkg::NUM_OUT_W-1:0] rn_nxt;
  logic signed [fau_pkg::DEN_OUT_W-1:0] rd_nxt;

  assign sn     = cmd.side ? nb_r : na_r;
  assign sd     = cmd.side ? db_r : da_r;
  assign dv_src = cmd.part ? sd : sn;
  assign g_val  = (x_r | y_r) << k_r;

  assign status.gcd_done = (x_r == '0) || (y_r == '0);
  assign status.gcd_zero = (x_r | y_r) == '0;
  assign status.div_done = cnt_r == CW'(W);
  assign status.out_busy = out_valid_r && !out_ready;

  assign rem_sh   = {rem_r, q_r[W-1]};
  assign diff     = rem_sh - {1'b0, g_r};
  assign q_signed = neg_r ? W'(-q_r) : q_r;

  always_comb begin
    unique case (cmd.mul_idx)
      2'd0: begin ma = fau_pkg::MUL_W'(na_r); mb = fau_pkg::MUL_W'(db_r); end
      2'd1: begin ma = fau_pkg::MUL_W'(da_r); mb = fau_pkg::MUL_W'(nb_r); end
      2'd2: begin ma = fau_pkg::MUL_W'(na_r); mb = fau_pkg::MUL_W'(nb_r); end
      default: begin ma = fau_pkg::MUL_W'(da_r); mb = fau_pkg::MUL_W'(db_r); end
    endcase
  end
  assign prod = ma * mb;

  always_comb begin
    unique case (op_r)
      fau_pkg::OP_ADD: begin
        rn_nxt = p0_r[fau_pkg::NUM_OUT_W-1:0] + p1_r[fau_pkg::NUM_OUT_W-1:0];
        rd_nxt = p3_r[fau_pkg::DEN_OUT_W-1:0];
      end
      fau_pkg::OP_SUB: begin
        rn_nxt = p0_r[fau_pkg::NUM_OUT_W-1:0] - p1_r[fau_pkg::NUM_OUT_W-1:0];
        rd_nxt = p3_r[fau_pkg::DEN_OUT_W-1:0];
      end
      fau_pkg::OP_MUL: begin
        rn_nxt = p2_r[fau_pkg::NUM_OUT_W-1:0];
        rd_nxt = p3_r[fau_pkg::DEN_OUT_W-1:0];
      end
      default: begin
        rn_nxt = p0_r[fau_pkg::NUM_OUT_W-1:0];
        rd_nxt = p1_r[fau_pkg::DEN_OUT_W-1:0];
      end
    endcase
  end

  // operand capture and quotient write-back
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= fau_pkg::op_t'(in_operation);
      na_r       <= take(in_num_a);
      da_r       <= take(in_den_a);
      nb_r       <= take(in_num_b);
      db_r       <= take(in_den_b);
      pos_a_r    <= pos(take(in_num_a), take(in_den_a));
      pos_b_r    <= pos(take(in_num_b), take(in_den_b));
      den_zero_r <= (take(in_den_a) == '0) || (take(in_den_b) == '0);
    end else if (cmd.div_write) begin
      unique case ({cmd.side, cmd.part})
        2'b00: na_r <= signed'(q_signed);
        2'b01: da_r <= signed'(q_signed);
        2'b10: nb_r <= signed'(q_signed);
        default: db_r <= signed'(q_signed);
      endcase
    end
  end

  // binary gcd
  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      x_r <= mag(sn);
      y_r <= mag(sd);
      k_r <= '0;
    end else if (cmd.gcd_step) begin
      priority if (!x_r[0] && !y_r[0]) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_r >= y_r) begin
        x_r <= (x_r - y_r) >> 1;
      end else begin
        y_r <= (y_r - x_r) >> 1;
      end
    end
    if (cmd.gcd_save) begin
      g_r <= g_val;
      if (cmd.side) begin
        irr_b_r <= g_val == W'(1);
      end else begin
        irr_a_r <= g_val == W'(1);
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_init) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      q_r   <= mag(dv_src);
      rem_r <= '0;
      neg_r <= dv_src[W-1];
    end else if (cmd.div_step) begin
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
        q_r   <= {q_r[W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[W-1:0];
        q_r   <= {q_r[W-2:0], 1'b0};
      end
    end
  end

  // cross products and the direct numerator and denominator products
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      unique case (cmd.mul_idx)
        2'd0: p0_r <= prod;
        2'd1: p1_r <= prod;
        2'd2: p2_r <= prod;
        default: p3_r <= prod;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rn_r     <= rn_nxt;
      rd_r     <= rd_nxt;
      fa_irr_r <= irr_a_r;
      fb_irr_r <= irr_b_r;
      fa_pos_r <= pos_a_r;
      fb_pos_r <= pos_b_r;
      err_r    <= den_zero_r || (rd_nxt == '0);
    end
  end

  assign out_valid              = out_valid_r;
  assign out_result_num         = rn_r;
  assign out_result_den         = rd_r;
  assign out_first_irreducible  = fa_irr_r;
  assign out_second_irreducible = fb_irr_r;
  assign out_first_positive     = fa_pos_r;
  assign out_second_positive    = fb_pos_r;
  assign out_error              = err_r;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ready))
    else $error("pending transaction overwritten");
  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> cnt_r != CW'(W))
    else $error("divider stepped past last bit");
  a_gcd_save: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gcd_save |-> (x_r == '0 || y_r == '0))
    else $error("gcd saved before completion");
  a_div_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_write |-> $past(cmd.div_step))
    else $error("quotient written without division");
`endif

endmodule

@@ src/fraction_arithmetic_unit_core.sv @@
// one transaction at a time, set by the shared binary gcd and bit-serial divider loop
// a new transaction is taken while a finished result waits in the output register
// synchronous active-low reset clears the controller and output valid, no clearing pass
module fraction_arithmetic_unit_core #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_operation,
  input  logic [fau_pkg::FIELD_W-1:0]            in_num_a,
  input  logic [fau_pkg::FIELD_W-1:0]            in_den_a,
  input  logic [fau_pkg::FIELD_W-1:0]            in_num_b,
  input  logic [fau_pkg::FIELD_W-1:0]            in_den_b,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fau_pkg::NUM_OUT_W-1:0]   out_result_num,
  output logic signed [fau_pkg::DEN_OUT_W-1:0]   out_result_den,
  output logic                                   out_first_irreducible,
  output logic                                   out_second_irreducible,
  output logic                                   out_first_positive,
  output logic                                   out_second_positive,
  output logic                                   out_error
);

  fau_pkg::cmd_t    cmd;
  fau_pkg::status_t status;

  fau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fau_dp #(
    .W (VALUE_WIDTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .status                 (status),
    .in_operation           (in_operation),
    .in_num_a               (in_num_a),
    .in_den_a               (in_den_a),
    .in_num_b               (in_num_b),
    .in_den_b               (in_den_b),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_result_num         (out_result_num),
    .out_result_den         (out_result_den),
    .out_first_irreducible  (out_first_irreducible),
    .out_second_irreducible (out_second_irreducible),
    .out_first_positive     (out_first_positive),
    .out_second_positive    (out_second_positive),
    .out_error              (out_error)
  );

endmodule

@@ tb/sv/tb_fraction_arithmetic_unit_core.sv @@
// self-checking testbench for the fraction arithmetic unit core
module tb_fraction_arithmetic_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    fau_pkg::op_t op;
    logic [15:0]  num_a;
    logic [15:0]  den_a;
    logic [15:0]  num_b;
    logic [15:0]  den_b;
  } frac_op_t;

  typedef struct packed {
    logic [32:0] rnum;
    logic [31:0] rden;
    logic        irr_a;
    logic        irr_b;
    logic        pos_a;
    logic        pos_b;
    logic        err;
  } frac_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_operation;
  logic [15:0] in_num_a, in_den_a, in_num_b, in_den_b;
  logic out_valid;
  logic out_ready;
  logic signed [32:0] out_result_num;
  logic signed [31:0] out_result_den;
  logic out_first_irreducible, out_second_irreducible;
  logic out_first_positive, out_second_positive, out_error;

  fraction_arithmetic_unit_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation),
    .in_num_a(in_num_a), .in_den_a(in_den_a),
    .in_num_b(in_num_b), .in_den_b(in_den_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_num(out_result_num), .out_result_den(out_result_den),
    .out_first_irreducible(out_first_irreducible),
    .out_second_irreducible(out_second_irreducible),
    .out_first_positive(out_first_positive),
    .out_second_positive(out_second_positive),
    .out_error(out_error)
  );

  frac_op_t  pending_ops[$];
  frac_res_t expected_results[$];
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int mismatches;
  int idle_cycles;

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t compute_fraction(frac_op_t t);
    frac_res_t r;
    longint na, da, nb, db, ga, gb, rn, rd;
    na = longint'($signed(t.num_a));
    da = longint'($signed(t.den_a));
    nb = longint'($signed(t.num_b));
    db = longint'($signed(t.den_b));
    r.pos_a = (na > 0 && da > 0) || (na < 0 && da < 0);
    r.pos_b = (nb > 0 && db > 0) || (nb < 0 && db < 0);
    ga = longint'(gcd_of(na < 0 ? -na : na, da < 0 ? -da : da));
    gb = longint'(gcd_of(nb < 0 ? -nb : nb, db < 0 ? -db : db));
    if (ga != 0) begin
      na = na / ga;
      da = da / ga;
    end
    if (gb != 0) begin
      nb = nb / gb;
      db = db / gb;
    end
    case (t.op)
      fau_pkg::OP_ADD: begin rn = na * db + da * nb; rd = da * db; end
      fau_pkg::OP_SUB: begin rn = na * db - da * nb; rd = da * db; end
      fau_pkg::OP_MUL: begin rn = na * nb; rd = da * db; end
      default: begin rn = na * db; rd = da * nb; end
    endcase
    r.rnum = rn[32:0];
    r.rden = rd[31:0];
    r.irr_a = (ga == 1);
    r.irr_b = (gb == 1);
    r.err = (da == 0) || (db == 0) || (r.rden == 0);
    return r;
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 7))
      0: return 16'(int'($urandom_range(0, 8)) - 4);
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'(($urandom_range(1, 180)) * ($urandom_range(1, 180)));
      4: return 16'($urandom_range(0, 255) * 64);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_op(fau_pkg::op_t op, int na, int da, int nb, int db);
    frac_op_t t;
    t.op = op;
    t.num_a = 16'(na);
    t.den_a = 16'(da);
    t.num_b = 16'(nb);
    t.den_b = 16'(db);
    pending_ops.push_back(t);
  endtask

  task automatic add_random(int n);
    frac_op_t t;
    repeat (n) begin
      t.op = fau_pkg::op_t'($urandom_range(0, 3));
      t.num_a = rand_field();
      t.den_a = rand_field();
      t.num_b = rand_field();
      t.den_b = rand_field();
      if ($urandom_range(0, 9) != 0) begin
        if (t.den_a == 0) t.den_a = 16'd1;
        if (t.den_b == 0) t.den_b = 16'hffff;
      end
      pending_ops.push_back(t);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        frac_op_t t;
        t = pending_ops.pop_front();
        expected_results.push_back(compute_fraction(t));
        in_valid <= 1'b1;
        in_operation <= t.op;
        in_num_a <= t.num_a;
        in_den_a <= t.den_a;
        in_num_b <= t.num_b;
        in_den_b <= t.den_b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      frac_res_t got, want;
      got = {out_result_num, out_result_den, out_first_irreducible,
             out_second_irreducible, out_first_positive, out_second_positive, out_error};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[fraction_arithmetic_unit_core] ERROR");
        $finish;
      end
    end
  end

  task automatic run_phase(int idle_pct, int stall_pct, int n);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    add_random(n);
    while (pending_ops.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = '0;
    in_num_a = '0;
    in_den_a = '0;
    in_num_b = '0;
    in_den_b = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    mismatches = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    add_op(fau_pkg::OP_ADD, 1, 2, 1, 3);
    add_op(fau_pkg::OP_SUB, 6, 8, 10, -4);
    add_op(fau_pkg::OP_MUL, -9, 12, -15, -25);
    add_op(fau_pkg::OP_DIV, 7, 3, 2, 5);
    add_op(fau_pkg::OP_DIV, 5, 7, 0, 9);
    add_op(fau_pkg::OP_ADD, 0, 6, 0, -1);
    add_op(fau_pkg::OP_SUB, 0, 1, 3, 0);
    add_op(fau_pkg::OP_MUL, 0, 0, 4, 4);
    add_op(fau_pkg::OP_ADD, 8, 0, 0, 0);
    add_op(fau_pkg::OP_ADD, -32768, -32768, 32767, 32767);
    add_op(fau_pkg::OP_SUB, -32768, 32767, 32767, -32768);
    add_op(fau_pkg::OP_MUL, -32768, 1, -32768, 1);
    add_op(fau_pkg::OP_DIV, -32768, 1, 1, -32768);
    add_op(fau_pkg::OP_DIV, 32767, 1, -1, 32767);
    add_op(fau_pkg::OP_ADD, -1, -1, 65535, 65535);
    add_op(fau_pkg::OP_SUB, 1, -32768, -1, -32768);
    add_op(fau_pkg::OP_MUL, 21845, 43690, 30000, 12000);
    add_op(fau_pkg::OP_DIV, 0, -5, 0, 7);
    while (pending_ops.size() != 0) @(posedge clk);

    run_phase(0, 0, 200);
    run_phase(51, 0, 150);
    run_phase(0, 51, 150);
    run_phase(34, 34, 150);
    hold_off_cycles = 600;
    run_phase(0, 0, 150);

    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[fraction_arithmetic_unit_core] OK");
    end else begin
      $display("[fraction_arithmetic_unit_core] ERROR");
    end
    $finish;
  end

endmodule
